// ===== hw/rtl/mer_pkg.sv =====
// Shared types, constants and the command builder for the encoder SPI reader.
package mer_pkg;

    localparam int unsigned FRAME_BITS = 16;
    localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS);

    localparam logic [15:0] CMD_READ_BIT   = 16'h4000;
    localparam logic [13:0] ANGLE_ADDR     = 14'h3FFF;
    localparam logic [15:0] CMD_PARITY_BIT = 16'h8000;
    localparam logic [15:0] FAST_COMMAND   = 16'hFFFF;
    localparam logic [15:0] ANGLE_ERR_WORD = 16'hFFFF;
    localparam logic [13:0] ANGLE_MASK     = 14'h3FFF;
    localparam int unsigned ERR_BIT        = 14;

    localparam logic [7:0] NORMAL_LEAD_RST  = 8'd200;
    localparam logic [7:0] FAST_LEAD_RST    = 8'd5;
    localparam logic [7:0] NORMAL_PHASE_RST = 8'd5;
    localparam logic [7:0] FAST_PHASE_RST   = 8'd3;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_NORMAL_LEAD  = 2'd0,
        REG_FAST_LEAD    = 2'd1,
        REG_NORMAL_PHASE = 2'd2,
        REG_FAST_PHASE   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_REG_READ   = 2'd0,
        MODE_ANGLE_READ = 2'd1,
        MODE_FAST_ANGLE = 2'd2,
        MODE_UNUSED     = 2'd3
    } req_mode_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_SETUP = 3'd2,
        PH_HIGH  = 3'd3,
        PH_LOW   = 3'd4,
        PH_GAP   = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  mode;
        logic [13:0] address;
        logic        miso;
    } in_item_t;

    typedef struct packed {
        logic        select_n;
        logic        serial_clock;
        logic        mosi;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        angle_error;
    } out_item_t;

    typedef struct packed {
        logic [7:0] normal_lead_ticks;
        logic [7:0] fast_lead_ticks;
        logic [7:0] normal_phase_ticks;
        logic [7:0] fast_phase_ticks;
    } cfg_t;

    // Read command with bit 15 chosen so that the whole word has even parity.
    function automatic logic [15:0] make_command(input logic [13:0] addr);
        logic [15:0] cmd;
        cmd = CMD_READ_BIT | {2'b00, addr};
        if (^cmd[14:0])
        begin
            cmd = cmd | CMD_PARITY_BIT;
        end
        return cmd;
    endfunction

    // A phase of n ticks reloads the down counter with n - 1; zero acts as one.
    function automatic logic [7:0] span(input logic [7:0] n);
        return (n == 8'd0) ? 8'd0 : n - 8'd1;
    endfunction

endpackage

// ===== hw/rtl/magnetic_encoder_spi_reader.sv =====
// Top level of the encoder SPI reader: timing registers, sequencer and result register.
//
// Each input beat on in_valid/in_ready is one timing tick of a 16-bit mode 1
// SPI master. A beat carries a start request, the request mode, the register
// address and the MISO level seen on that tick. Every accepted beat yields
// exactly one result beat on out_valid/out_ready: the select, clock and MOSI
// pin levels after that tick, busy and done flags, and the last read result.
// Each result beat is registered and appears in the cycle after its input beat,
// and a new beat is accepted every cycle, limited only by the single result register.
// When the receiver stalls, the result register holds its beat and in_ready
// drops until that beat is taken; beats are never lost or repeated.
// The frame sequencer state only advances on accepted beats.
// The four timing registers sit on an APB port at byte addresses 0, 4, 8
// and 12 (normal lead, fast lead, normal phase, fast phase ticks) and
// should be written only while the block is idle.
// Reset returns the sequencer to idle, clears the last result and loads the
// timing registers with 200, 5, 5 and 3 ticks.
module magnetic_encoder_spi_reader (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mer_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mer_pkg::out_item_t                 out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mer_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mer_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mer_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import mer_pkg::*;

    cfg_t      cfg_reg;
    out_item_t result;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    logic      in_fire;
    logic      cfg_write;
    reg_idx_t  reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_lead_ticks  <= NORMAL_LEAD_RST;
            cfg_reg.fast_lead_ticks    <= FAST_LEAD_RST;
            cfg_reg.normal_phase_ticks <= NORMAL_PHASE_RST;
            cfg_reg.fast_phase_ticks   <= FAST_PHASE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_NORMAL_LEAD:  cfg_reg.normal_lead_ticks  <= pwdata[7:0];
                REG_FAST_LEAD:    cfg_reg.fast_lead_ticks    <= pwdata[7:0];
                REG_NORMAL_PHASE: cfg_reg.normal_phase_ticks <= pwdata[7:0];
                REG_FAST_PHASE:   cfg_reg.fast_phase_ticks   <= pwdata[7:0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NORMAL_LEAD:  prdata = {24'd0, cfg_reg.normal_lead_ticks};
            REG_FAST_LEAD:    prdata = {24'd0, cfg_reg.fast_lead_ticks};
            REG_NORMAL_PHASE: prdata = {24'd0, cfg_reg.normal_phase_ticks};
            REG_FAST_PHASE:   prdata = {24'd0, cfg_reg.fast_phase_ticks};
            default:          prdata = '0;
        endcase
    end

    // The result register frees itself in the same cycle its beat is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    mer_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .item    (in_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/mer_seq.sv =====
// Pin-level sequencer: advances the SPI frame state by one tick per accepted beat.
module mer_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  mer_pkg::in_item_t item,
    input  mer_pkg::cfg_t     cfg,
    output mer_pkg::out_item_t result
);
    import mer_pkg::*;

    phase_t               phase_reg,  phase_next;
    logic [7:0]           tick_reg,   tick_next;
    logic [BIT_IDX_W-1:0] bit_reg,    bit_next;
    logic                 frame_reg,  frame_next;
    logic [15:0]          cmd_reg,    cmd_next;
    logic [15:0]          resp_reg,   resp_next;
    logic [1:0]           mode_reg,   mode_next;
    logic [15:0]          result_reg, result_next;

    logic fast;
    logic fast_next;
    logic sel;

    assign fast = (mode_reg == MODE_FAST_ANGLE);

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        frame_next  = frame_reg;
        cmd_next    = cmd_reg;
        resp_next   = resp_reg;
        mode_next   = mode_reg;
        result_next = result_reg;
        fast_next   = fast;

        case (phase_reg)
            PH_LEAD, PH_SETUP, PH_HIGH, PH_LOW, PH_GAP:
            begin
                if (tick_reg != 8'd0)
                begin
                    tick_next = tick_reg - 8'd1;
                end
                else
                begin
                    case (phase_reg)
                        PH_LEAD:
                        begin
                            if (fast)
                            begin
                                phase_next = PH_HIGH;
                                tick_next  = span(cfg.fast_phase_ticks);
                            end
                            else
                            begin
                                phase_next = PH_SETUP;
                                tick_next  = span(cfg.normal_phase_ticks);
                            end
                        end
                        PH_SETUP:
                        begin
                            phase_next = PH_HIGH;
                            tick_next  = span(cfg.normal_phase_ticks);
                        end
                        PH_HIGH:
                        begin
                            phase_next = PH_LOW;
                            if (fast)
                            begin
                                resp_next = {resp_reg[14:0], item.miso};
                                tick_next = span(cfg.fast_phase_ticks);
                            end
                            else
                            begin
                                tick_next = span(cfg.normal_phase_ticks);
                            end
                        end
                        PH_LOW:
                        begin
                            if (!fast)
                            begin
                                resp_next = {resp_reg[14:0], item.miso};
                            end
                            if (bit_reg != '0)
                            begin
                                bit_next = bit_reg - 1'b1;
                                if (fast)
                                begin
                                    phase_next = PH_HIGH;
                                    tick_next  = span(cfg.fast_phase_ticks);
                                end
                                else
                                begin
                                    phase_next = PH_SETUP;
                                    tick_next  = span(cfg.normal_phase_ticks);
                                end
                            end
                            else if (!fast && !frame_reg)
                            begin
                                frame_next = 1'b1;
                                phase_next = PH_GAP;
                                tick_next  = 8'd0;
                            end
                            else
                            begin
                                if (mode_reg == MODE_REG_READ)
                                begin
                                    result_next = resp_next;
                                end
                                else if (mode_reg == MODE_ANGLE_READ && resp_next[ERR_BIT])
                                begin
                                    result_next = ANGLE_ERR_WORD;
                                end
                                else
                                begin
                                    result_next = {2'b00, resp_next[13:0] & ANGLE_MASK};
                                end
                                phase_next = PH_DONE;
                                tick_next  = 8'd0;
                            end
                        end
                        default:
                        begin
                            // Gap between the two frames: start the second frame.
                            resp_next  = '0;
                            bit_next   = BIT_IDX_W'(FRAME_BITS - 1);
                            phase_next = PH_LEAD;
                            tick_next  = span(cfg.normal_lead_ticks);
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (item.start_req && item.mode != MODE_UNUSED)
                begin
                    mode_next  = item.mode;
                    fast_next  = (item.mode == MODE_FAST_ANGLE);
                    cmd_next   = fast_next ? FAST_COMMAND :
                                 make_command((item.mode == MODE_ANGLE_READ) ?
                                              ANGLE_ADDR : item.address);
                    frame_next = 1'b0;
                    resp_next  = '0;
                    bit_next   = BIT_IDX_W'(FRAME_BITS - 1);
                    phase_next = PH_LEAD;
                    tick_next  = fast_next ? span(cfg.fast_lead_ticks)
                                           : span(cfg.normal_lead_ticks);
                end
            end
        endcase
    end

    // Pins as driven after this tick's update.
    assign sel = (phase_next == PH_LEAD) || (phase_next == PH_SETUP) ||
                 (phase_next == PH_HIGH) || (phase_next == PH_LOW);

    always_comb
    begin
        result.select_n     = !sel;
        result.serial_clock = (phase_next == PH_HIGH);
        result.mosi         = ((phase_next == PH_SETUP) || (phase_next == PH_HIGH) ||
                               (phase_next == PH_LOW)) && cmd_next[bit_next];
        result.busy_res     = (phase_next != PH_IDLE) && (phase_next != PH_DONE);
        result.done_res     = (phase_next == PH_DONE);
        result.read_data    = result_next;
        result.angle_error  = (mode_next == MODE_ANGLE_READ) &&
                              (result_next == ANGLE_ERR_WORD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            frame_reg  <= 1'b0;
            cmd_reg    <= '0;
            resp_reg   <= '0;
            mode_reg   <= '0;
            result_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            frame_reg  <= frame_next;
            cmd_reg    <= cmd_next;
            resp_reg   <= resp_next;
            mode_reg   <= mode_next;
            result_reg <= result_next;
        end
    end

endmodule

// ===== tb/magnetic_encoder_spi_reader_test.sv =====
// Self-checking testbench for the encoder SPI reader with a shadow tick-level sequencer.
module magnetic_encoder_spi_reader_test;

    import mer_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_PCT     = 8;
    localparam int RANDOM_TICKS = 1900;

    localparam int MISO_ZERO = 0;
    localparam int MISO_ONE  = 1;
    localparam int MISO_RAND = 2;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    magnetic_encoder_spi_reader u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Shadow copy of the sequencer and its timing registers.
    cfg_t        enc_cfg;
    phase_t      enc_phase;
    logic [7:0]  enc_ticks;
    logic [3:0]  enc_bit;
    logic        enc_frame;
    logic [15:0] enc_cmd;
    logic [15:0] enc_resp;
    logic [15:0] enc_last;
    req_mode_t   enc_mode;

    in_item_t  tick_queue[$];
    out_item_t pins_due[$];
    out_item_t want_pins;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int beats_owed     = 0;
    int stim_ticks     = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    bit beat_in        = 1'b0;
    bit steady         = 1'b0;

    function automatic void go_phase(input phase_t ph, input logic [7:0] n);
        enc_phase = ph;
        enc_ticks = (n == 8'd0) ? 8'd0 : n - 8'd1;
    endfunction

    function automatic void frame_begin();
        enc_resp = '0;
        enc_bit  = 4'd15;
        go_phase(PH_LEAD, (enc_mode == MODE_FAST_ANGLE) ? enc_cfg.fast_lead_ticks
                                                        : enc_cfg.normal_lead_ticks);
    endfunction

    // Advances the shadow sequencer by one tick and returns the pins after it.
    function automatic out_item_t encoder_tick(input in_item_t it);
        logic        fast;
        logic [13:0] cmd_addr;
        out_item_t   pins;
        fast = (enc_mode == MODE_FAST_ANGLE);
        if (enc_phase == PH_IDLE || enc_phase == PH_DONE)
        begin
            enc_phase = PH_IDLE;
            if (it.start_req && it.mode != MODE_UNUSED)
            begin
                enc_mode = req_mode_t'(it.mode);
                cmd_addr = (enc_mode == MODE_ANGLE_READ) ? ANGLE_ADDR : it.address;
                // Bit 15 makes the parity of the whole word even.
                enc_cmd = {1'b1 ^ (^cmd_addr), 1'b1, cmd_addr};
                if (enc_mode == MODE_FAST_ANGLE)
                begin
                    enc_cmd = FAST_COMMAND;
                end
                enc_frame = 1'b0;
                frame_begin();
            end
        end
        else if (enc_ticks != 8'd0)
        begin
            enc_ticks = enc_ticks - 8'd1;
        end
        else
        begin
            case (enc_phase)
                PH_LEAD:
                begin
                    if (fast)
                        go_phase(PH_HIGH, enc_cfg.fast_phase_ticks);
                    else
                        go_phase(PH_SETUP, enc_cfg.normal_phase_ticks);
                end
                PH_SETUP:
                begin
                    go_phase(PH_HIGH, enc_cfg.normal_phase_ticks);
                end
                PH_HIGH:
                begin
                    if (fast)
                    begin
                        enc_resp = {enc_resp[14:0], it.miso};
                        go_phase(PH_LOW, enc_cfg.fast_phase_ticks);
                    end
                    else
                    begin
                        go_phase(PH_LOW, enc_cfg.normal_phase_ticks);
                    end
                end
                PH_LOW:
                begin
                    if (!fast)
                    begin
                        enc_resp = {enc_resp[14:0], it.miso};
                    end
                    if (enc_bit != 4'd0)
                    begin
                        enc_bit = enc_bit - 4'd1;
                        if (fast)
                            go_phase(PH_HIGH, enc_cfg.fast_phase_ticks);
                        else
                            go_phase(PH_SETUP, enc_cfg.normal_phase_ticks);
                    end
                    else if (!fast && !enc_frame)
                    begin
                        enc_frame = 1'b1;
                        enc_phase = PH_GAP;
                        enc_ticks = 8'd0;
                    end
                    else
                    begin
                        if (enc_mode == MODE_REG_READ)
                            enc_last = enc_resp;
                        else if (enc_mode == MODE_ANGLE_READ && enc_resp[ERR_BIT])
                            enc_last = ANGLE_ERR_WORD;
                        else
                            enc_last = {2'b00, enc_resp[13:0]};
                        enc_phase = PH_DONE;
                        enc_ticks = 8'd0;
                    end
                end
                default:
                begin
                    frame_begin();
                end
            endcase
        end

        pins.select_n     = !(enc_phase == PH_LEAD || enc_phase == PH_SETUP ||
                              enc_phase == PH_HIGH || enc_phase == PH_LOW);
        pins.serial_clock = (enc_phase == PH_HIGH);
        pins.mosi         = (enc_phase == PH_SETUP || enc_phase == PH_HIGH ||
                             enc_phase == PH_LOW) && enc_cmd[enc_bit];
        pins.busy_res     = (enc_phase != PH_IDLE && enc_phase != PH_DONE);
        pins.done_res     = (enc_phase == PH_DONE);
        pins.read_data    = enc_last;
        pins.angle_error  = (enc_mode == MODE_ANGLE_READ && enc_last == ANGLE_ERR_WORD);
        return pins;
    endfunction

    function automatic void push_tick(input logic s, input logic [1:0] m,
                                      input logic [13:0] a, input int miso_kind);
        in_item_t it;
        it.start_req = s;
        it.mode      = m;
        it.address   = a;
        if (miso_kind == MISO_RAND)
            it.miso = 1'($urandom_range(1));
        else
            it.miso = (miso_kind == MISO_ONE);
        tick_queue.push_back(it);
        beats_owed++;
        stim_ticks++;
    endfunction

    // A start tick followed by exactly enough ticks to reach the done tick, so
    // that a following request starts on the tick right after done.
    function automatic void queue_request(input req_mode_t m, input logic [13:0] a,
                                          input int miso_kind);
        int lead;
        int step;
        int n;
        if (m == MODE_FAST_ANGLE)
        begin
            lead = (enc_cfg.fast_lead_ticks == 8'd0) ? 1 : enc_cfg.fast_lead_ticks;
            step = (enc_cfg.fast_phase_ticks == 8'd0) ? 1 : enc_cfg.fast_phase_ticks;
            n    = lead + 32 * step + 1;
        end
        else
        begin
            lead = (enc_cfg.normal_lead_ticks == 8'd0) ? 1 : enc_cfg.normal_lead_ticks;
            step = (enc_cfg.normal_phase_ticks == 8'd0) ? 1 : enc_cfg.normal_phase_ticks;
            n    = 2 * lead + 96 * step + 2;
        end
        push_tick(1'b1, m, a, miso_kind);
        // Starts inside a running request must be ignored by the block.
        for (int k = 1; k < n; k++)
        begin
            push_tick($urandom_range(15) == 0, 2'($urandom_range(3)), 14'($urandom),
                      miso_kind);
        end
    endfunction

    task automatic write_timing(input reg_idx_t idx, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NORMAL_LEAD:  enc_cfg.normal_lead_ticks  = value;
            REG_FAST_LEAD:    enc_cfg.fast_lead_ticks    = value;
            REG_NORMAL_PHASE: enc_cfg.normal_phase_ticks = value;
            default:          enc_cfg.fast_phase_ticks   = value;
        endcase
    endtask

    task automatic set_timing(input logic [7:0] nl, input logic [7:0] fl,
                              input logic [7:0] np, input logic [7:0] fp);
        write_timing(REG_NORMAL_LEAD, nl);
        write_timing(REG_FAST_LEAD, fl);
        write_timing(REG_NORMAL_PHASE, np);
        write_timing(REG_FAST_PHASE, fp);
    endtask

    task automatic drain();
        while (beats_owed != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Waits for every result, then pads with idle ticks until the sequencer is idle.
    task automatic settle();
        drain();
        while (enc_phase != PH_IDLE)
        begin
            push_tick(1'b0, MODE_REG_READ, 14'd0, MISO_RAND);
            drain();
        end
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_in = in_valid && in_ready;
            if (beat_in)
            begin
                pins_due.push_back(encoder_tick(in_data));
            end
            if (out_valid && out_ready)
            begin
                if (pins_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Cycle %0d: result beat %h with none predicted",
                                 cycle_count, out_data);
                end
                else
                begin
                    want_pins = pins_due.pop_front();
                    beats_owed--;
                    if (out_data.select_n !== want_pins.select_n ||
                        out_data.serial_clock !== want_pins.serial_clock ||
                        out_data.mosi !== want_pins.mosi ||
                        out_data.busy_res !== want_pins.busy_res ||
                        out_data.done_res !== want_pins.done_res ||
                        out_data.read_data !== want_pins.read_data ||
                        out_data.angle_error !== want_pins.angle_error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("Cycle %0d: expected sel_n=%b sclk=%b mosi=%b busy=%b",
                                     cycle_count, want_pins.select_n,
                                     want_pins.serial_clock, want_pins.mosi,
                                     want_pins.busy_res, " done=%b data=%h err=%b",
                                     want_pins.done_res, want_pins.read_data,
                                     want_pins.angle_error);
                            $display("Cycle %0d: actual   sel_n=%b sclk=%b mosi=%b busy=%b",
                                     cycle_count, out_data.select_n,
                                     out_data.serial_clock, out_data.mosi,
                                     out_data.busy_res, " done=%b data=%h err=%b",
                                     out_data.done_res, out_data.read_data,
                                     out_data.angle_error);
                        end
                    end
                end
            end
        end
    end

    // Sender: a beat stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_in))
        begin
            if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                in_data  <= tick_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver, with an occasional long hold-off that backs up the input side.
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int         round;
        int         target;
        int         pick;
        logic [7:0] lead_n;
        logic [7:0] lead_f;

        enc_cfg   = '{NORMAL_LEAD_RST, FAST_LEAD_RST, NORMAL_PHASE_RST, FAST_PHASE_RST};
        enc_phase = PH_IDLE;
        enc_ticks = '0;
        enc_bit   = '0;
        enc_frame = 1'b0;
        enc_cmd   = '0;
        enc_resp  = '0;
        enc_last  = '0;
        enc_mode  = MODE_REG_READ;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Timing left at its reset values.
        queue_request(MODE_FAST_ANGLE, 14'($urandom), MISO_RAND);
        queue_request(MODE_ANGLE_READ, 14'($urandom), MISO_RAND);
        settle();

        // Shortest timing, with a long receiver stall over the first requests.
        set_timing(8'd1, 8'd1, 8'd1, 8'd1);
        hold_asks++;
        queue_request(MODE_REG_READ, 14'h3FFF, MISO_ONE);
        queue_request(MODE_ANGLE_READ, 14'h0000, MISO_ONE);
        queue_request(MODE_FAST_ANGLE, 14'h0000, MISO_ZERO);
        push_tick(1'b1, MODE_UNUSED, 14'h3FFF, MISO_ONE);
        push_tick(1'b0, MODE_REG_READ, 14'h0000, MISO_ZERO);
        settle();

        // A zero timing register behaves as one tick.
        set_timing(8'd0, 8'd0, 8'd0, 8'd0);
        queue_request(MODE_REG_READ, 14'($urandom), MISO_RAND);
        queue_request(MODE_FAST_ANGLE, 14'($urandom), MISO_RAND);
        settle();

        round = 0;
        while (round < 3 || stim_ticks < RANDOM_TICKS)
        begin
            round++;
            steady = (round == 3);
            if (round == 2)
            begin
                hold_asks++;
            end
            if ($urandom_range(3) == 0)
            begin
                lead_n = 8'($urandom_range(60, 9));
                lead_f = 8'($urandom_range(60, 9));
            end
            else
            begin
                lead_n = 8'($urandom_range(8, 1));
                lead_f = 8'($urandom_range(8, 1));
            end
            set_timing(lead_n, lead_f, 8'($urandom_range(3, 1)), 8'($urandom_range(3, 1)));
            target = stim_ticks + 150;
            while (stim_ticks < target)
            begin
                pick = $urandom_range(19);
                if (pick == 0)
                begin
                    push_tick(1'b1, MODE_UNUSED, 14'($urandom), MISO_RAND);
                end
                else if (pick == 1)
                begin
                    repeat ($urandom_range(4, 1))
                    begin
                        push_tick(1'b0, 2'($urandom_range(3)), 14'($urandom), MISO_RAND);
                    end
                end
                else
                begin
                    queue_request(req_mode_t'($urandom_range(2)), 14'($urandom), MISO_RAND);
                end
            end
            settle();
        end
        steady = 1'b0;

        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && pins_due.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
